// ===== rtl/sgr_pkg.sv =====
// sgr_pkg: shared widths, defaults and reset values for the stream group reverser.
// No dependencies; used by stream_group_reverser_top.
`default_nettype none

package sgr_pkg;

    localparam int DATA_W         = 32;
    localparam int CFG_W          = 5;
    localparam int MAX_GROUP_DEF  = 16;
    localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 5'd4;

endpackage

`default_nettype wire

// ===== rtl/stream_group_reverser_top.sv =====
// stream_group_reverser_top: collects values into groups and emits full groups reversed.
// Depends on sgr_pkg and sgr_ram.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, item_value, last_item | sink
//  out     | out_valid, out_ready, out_value,          | source
//          | run_last, list_end                        |
//  cfg     | cfg_write_en, cfg_write_data              | sink
//
// A short group closed by last_item is emitted in its input order, not reversed.
// A beat that closes a group of n values is followed by n reads through the RAM
// read port, one result a cycle while the output is not stalled; no input is taken.
// The RAM output register is the output register; a stalled output holds the read.
// Reset clears the fill count, the state and out_valid; group_size resets to 4.
`default_nettype none

module stream_group_reverser_top #(
    parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [sgr_pkg::CFG_W-1:0]        cfg_write_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [sgr_pkg::DATA_W-1:0] item_value,
    input  wire logic                             last_item,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [sgr_pkg::DATA_W-1:0]     out_value,
    output logic                                  run_last,
    output logic                                  list_end
);

    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int AW    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CMP_W = (CNT_W > sgr_pkg::CFG_W) ? CNT_W : sgr_pkg::CFG_W;

    typedef enum logic [1:0] {
        ST_FILL = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                       state_reg,     state_next;
    logic [sgr_pkg::CFG_W-1:0]    group_size_reg;
    logic [CNT_W-1:0]             fill_reg,      fill_next;
    logic [AW-1:0]                idx_reg,       idx_next;
    logic [AW-1:0]                last_idx_reg,  last_idx_next;
    logic                         rev_reg,       rev_next;
    logic                         end_reg,       end_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         run_last_reg,  run_last_next;
    logic                         list_end_reg,  list_end_next;

    logic [CMP_W-1:0]             cfg_ext;
    logic [CNT_W-1:0]             g_eff;
    logic [CNT_W-1:0]             n_w;
    logic                         in_fire;
    logic                         advance;
    logic                         issue;
    logic                         fin;
    logic [AW-1:0]                rd_addr;
    logic [sgr_pkg::DATA_W-1:0]   rd_data;

    always_comb
    begin
        cfg_ext = CMP_W'(group_size_reg);
        if (group_size_reg == '0)
        begin
            g_eff = CNT_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_GROUP))
        begin
            g_eff = CNT_W'(MAX_GROUP);
        end
        else
        begin
            g_eff = CNT_W'(cfg_ext);
        end
    end

    assign n_w      = fill_reg + CNT_W'(1);
    assign in_ready = (state_reg == ST_FILL);
    assign in_fire  = in_valid && in_ready;
    assign advance  = !out_valid_reg || out_ready;
    assign issue    = (state_reg == ST_EMIT) && advance;
    assign fin      = (idx_reg == last_idx_reg);
    assign rd_addr  = rev_reg ? (last_idx_reg - idx_reg) : idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        rev_next       = rev_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg;
        run_last_next  = run_last_reg;
        list_end_next  = list_end_reg;

        if (advance)
        begin
            out_valid_next = issue;
            run_last_next  = fin;
            list_end_next  = fin && end_reg;
        end

        case (state_reg)
            ST_FILL:
            begin
                if (in_fire)
                begin
                    if ((n_w >= g_eff) || last_item)
                    begin
                        state_next    = ST_EMIT;
                        idx_next      = '0;
                        last_idx_next = fill_reg[AW-1:0];
                        rev_next      = (n_w >= g_eff);
                        end_next      = last_item;
                        fill_next     = '0;
                    end
                    else
                    begin
                        fill_next = n_w;
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    if (fin)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            group_size_reg <= sgr_pkg::GROUP_SIZE_RST;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                group_size_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        rev_reg      <= rev_next;
        end_reg      <= end_next;
        run_last_reg <= run_last_next;
        list_end_reg <= list_end_next;
    end

    sgr_ram #(
        .WIDTH (sgr_pkg::DATA_W),
        .DEPTH (MAX_GROUP)
    ) u_buf (
        .clk   (clk),
        .we    (in_fire),
        .waddr (fill_reg[AW-1:0]),
        .wdata (item_value),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign out_value = signed'(rd_data);
    assign run_last  = run_last_reg;
    assign list_end  = list_end_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CNT_W'(MAX_GROUP))
        else $error("fill count reached group buffer depth");

    a_list_end_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && list_end) |-> run_last)
        else $error("list_end without run_last");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !((n_w >= g_eff) || last_item)) |=> (fill_reg == $past(n_w)))
        else $error("fill count did not advance by one");

    a_emit_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (idx_reg <= last_idx_reg))
        else $error("read index ran past group end");

    a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ((n_w >= g_eff) || last_item)) |=> (state_reg == ST_EMIT && fill_reg == '0))
        else $error("closing beat did not start emission");
`endif

endmodule

`default_nettype wire

// ===== rtl/sgr_ram.sv =====
// sgr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module sgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_stream_group_reverser_top.sv =====
// Self-checking testbench for stream_group_reverser_top: directed and random value lists
// under several group sizes, with random idling on both channels. Depends on sgr_pkg and
// the RTL only; expected beats come from a group-reversal predictor built into this file.
module tb_stream_group_reverser_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W      = sgr_pkg::DATA_W;
    localparam int CFG_W       = sgr_pkg::CFG_W;
    localparam int MAX_GROUP   = sgr_pkg::MAX_GROUP_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 4;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } list_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     run_last;
        logic                     list_end;
    } group_beat_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write_en = 1'b0;
    logic [CFG_W-1:0]         cfg_write_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] item_value = '0;
    logic                     last_item = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] out_value;
    logic                     run_last;
    logic                     list_end;

    list_beat_t               list_feed[$];
    group_beat_t              pending_groups[$];

    logic signed [DATA_W-1:0] held_values[MAX_GROUP];
    int                       held_count = 0;
    logic [CFG_W-1:0]         group_size = sgr_pkg::GROUP_SIZE_RST;

    int                       beats_taken = 0;
    int                       beats_offered = 0;
    int                       send_gap = 0;
    int                       recv_stall = 0;
    int                       send_idle_pct = 0;
    int                       recv_idle_pct = 0;
    int                       mismatches = 0;
    int                       cycle_count = 0;

    stream_group_reverser_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .item_value     (item_value),
        .last_item      (last_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_value      (out_value),
        .run_last       (run_last),
        .list_end       (list_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic predict_reversal(input logic signed [DATA_W-1:0] v, input logic last);
        int          g;
        int          n;
        group_beat_t r;
        g = int'(group_size);
        if (g == 0)
            g = 1;
        if (g > MAX_GROUP)
            g = MAX_GROUP;
        if (held_count >= MAX_GROUP)
            held_count = MAX_GROUP - 1;
        held_values[held_count] = v;
        held_count++;
        n = held_count;
        if (n >= g)
        begin
            for (int k = 0; k < n; k++)
            begin
                r.value    = held_values[n-1-k];
                r.run_last = (k == n - 1);
                r.list_end = (k == n - 1) && last;
                pending_groups.push_back(r);
            end
            held_count = 0;
        end
        else if (last)
        begin
            for (int k = 0; k < n; k++)
            begin
                r.value    = held_values[k];
                r.run_last = (k == n - 1);
                r.list_end = (k == n - 1);
                pending_groups.push_back(r);
            end
            held_count = 0;
        end
    endtask

    task automatic check_group_beat();
        group_beat_t e;
        if (pending_groups.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected output beat value=%0d run_last=%0b list_end=%0b",
                     $realtime, out_value, run_last, list_end);
        end
        else
        begin
            e = pending_groups.pop_front();
            if (out_value !== e.value)
            begin
                mismatches++;
                $display("%0t: out_value expected %0d actual %0d",
                         $realtime, e.value, out_value);
            end
            if (run_last !== e.run_last)
            begin
                mismatches++;
                $display("%0t: run_last expected %0b actual %0b",
                         $realtime, e.run_last, run_last);
            end
            if (list_end !== e.list_end)
            begin
                mismatches++;
                $display("%0t: list_end expected %0b actual %0b",
                         $realtime, e.list_end, list_end);
            end
        end
    endtask

    // monitor: output check first, then prediction for the input beat of this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_group_beat();
            if (in_valid && in_ready)
            begin
                predict_reversal(item_value, last_item);
                beats_taken <= beats_taken + 1;
            end
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && beats_taken != beats_offered)
            begin
                // beat still waiting for in_ready
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (list_feed.size() == 0)
                in_valid <= 1'b0;
            else if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            begin
                send_gap = $urandom_range(9);
                in_valid <= 1'b0;
            end
            else
            begin
                {item_value, last_item} <= list_feed.pop_front();
                in_valid <= 1'b1;
                beats_offered <= beats_offered + 1;
            end
        end
    end

    // output stall generator
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct)
            begin
                recv_stall = $urandom_range(9);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** stream_group_reverser_top: FAILED **");
            $finish;
        end
    end

    task automatic write_group_size(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        group_size = v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // sampled just after the falling edge so driver updates have settled
    task automatic wait_drained();
        @(negedge clk);
        #1;
        while (list_feed.size() != 0 || in_valid || beats_taken != beats_offered ||
               pending_groups.size() != 0)
        begin
            @(negedge clk);
            #1;
        end
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // lists of random length; a few beats get a random end flag, stray or dropped
    task automatic queue_lists(input int count);
        int len;
        int pos;
        logic last;
        len = 0;
        pos = 0;
        for (int i = 0; i < count; i++)
        begin
            if (pos == len)
            begin
                len = ($urandom_range(7) == 0) ? 1 : $urandom_range(1, 40);
                pos = 0;
            end
            pos++;
            last = (pos == len);
            if ($urandom_range(9) == 0)
                last = 1'($urandom_range(1));
            list_feed.push_back('{pick_value(), last});
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] size, input int count,
                             input int send_pct, input int recv_pct, input bit drain_mid);
        write_group_size(size);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_lists(count / 2);
        if (drain_mid)
            wait_drained();
        queue_lists(count - count / 2);
        wait_drained();
    endtask

    initial
    begin
        logic [CFG_W-1:0] sizes[10];
        sizes = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd2, 5'd0, 5'd0, 5'd16, 5'd0};
        for (int i = 0; i < 10; i++)
            if (i == 6 || i == 7 || i == 9)
                sizes[i] = CFG_W'($urandom_range(31));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        out_ready <= 1'b1;

        // reset size of 4: extremes as one group, short tail, list ending on a full group
        list_feed.push_back('{32'sh7FFF_FFFF, 1'b0});
        list_feed.push_back('{32'sh8000_0000, 1'b0});
        list_feed.push_back('{-32'sd1, 1'b0});
        list_feed.push_back('{32'sd0, 1'b0});
        list_feed.push_back('{32'sd1, 1'b0});
        list_feed.push_back('{32'sd2, 1'b1});
        for (int i = 5; i <= 8; i++)
            list_feed.push_back('{i, i == 8});
        wait_drained();

        // size zero behaves as one
        write_group_size(5'd0);
        for (int i = 0; i < 3; i++)
            list_feed.push_back('{-32'sd100 - i, i == 2});
        wait_drained();

        write_group_size(5'd1);
        list_feed.push_back('{32'sh1234_5678, 1'b0});
        list_feed.push_back('{-32'sd7, 1'b1});
        wait_drained();

        // oversize saturates; leave five held, then shrink the group below the held count
        write_group_size(5'd31);
        for (int i = 0; i < 5; i++)
            list_feed.push_back('{32'sd1000 + i, 1'b0});
        wait_drained();
        write_group_size(5'd2);
        list_feed.push_back('{32'sd2000, 1'b1});
        wait_drained();

        for (int p = 0; p < 10; p++)
        begin
            if (p >= 8)
                run_phase(sizes[p], 20, 0, 0, 1'b0);
            else
                run_phase(sizes[p], 20, (p % 3) * 25, ((p + 1) % 3) * 25, p == 2 || p == 5);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_groups.size() == 0)
            $display("** stream_group_reverser_top: PASSED **");
        else
            $display("** stream_group_reverser_top: FAILED **");
        $finish;
    end

endmodule
